FILE: rtl/odo_pkg.sv
// Shared types, constants and arithmetic helpers for the three-encoder odometry integrator.
`default_nettype none
package odo_pkg;

   localparam int FRAC_BITS        = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN         = 30;

   localparam int ANG_W      = 32;
   localparam int HEAD_OUT_W = 19;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 88;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   localparam longint TENTH_Q32 = 64'd429496730;
   localparam longint PI_Q30    = 64'd3373259426;
   localparam longint PI_QF     = (PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
   localparam longint TWO_PI_QF = 2 * PI_QF;

   localparam int HEAD_W = $clog2(PI_QF + 1) + 1;

   localparam int     WRAP_W     = 33;
   localparam longint WRAP_BIAS  = TWO_PI_QF * (64'd2147483648 / TWO_PI_QF + 1);
   localparam int     WRAP_TOP   = WRAP_W - $clog2(TWO_PI_QF);
   localparam int     WRAP_CNT_W = $clog2(WRAP_TOP + 1);

   localparam int     Z_W          = 34;
   localparam int     XY_W         = 34;
   localparam int     CS_W         = FRAC_BITS + 3;
   localparam int     CORDIC_SHIFT = 30 - FRAC_BITS;
   localparam longint CORDIC_K_Q30 = 64'd652032875;
   localparam longint HALF_PI_Q30  = PI_Q30 / 2;

   localparam logic [CSR_DATA_W-1:0] GAIN_RESET = 32'd327680;

   localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] S32_MIN = -PROD_W'(64'sd2147483648);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TURN_GAIN   = 1'b0,
      CSR_FRONT_LEVER = 1'b1
   } odo_csr_type;

   function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:    v = Z_W'(64'sd843314857);
         5'd1:    v = Z_W'(64'sd497837829);
         5'd2:    v = Z_W'(64'sd263043837);
         5'd3:    v = Z_W'(64'sd133525159);
         5'd4:    v = Z_W'(64'sd67021687);
         5'd5:    v = Z_W'(64'sd33543516);
         5'd6:    v = Z_W'(64'sd16775851);
         5'd7:    v = Z_W'(64'sd8388437);
         5'd8:    v = Z_W'(64'sd4194283);
         5'd9:    v = Z_W'(64'sd2097149);
         5'd10:   v = Z_W'(64'sd1048576);
         5'd11:   v = Z_W'(64'sd524288);
         5'd12:   v = Z_W'(64'sd262144);
         5'd13:   v = Z_W'(64'sd131072);
         5'd14:   v = Z_W'(64'sd65536);
         5'd15:   v = Z_W'(64'sd32768);
         5'd16:   v = Z_W'(64'sd16384);
         5'd17:   v = Z_W'(64'sd8192);
         5'd18:   v = Z_W'(64'sd4096);
         5'd19:   v = Z_W'(64'sd2048);
         5'd20:   v = Z_W'(64'sd1024);
         5'd21:   v = Z_W'(64'sd512);
         5'd22:   v = Z_W'(64'sd256);
         5'd23:   v = Z_W'(64'sd128);
         5'd24:   v = Z_W'(64'sd64);
         5'd25:   v = Z_W'(64'sd32);
         5'd26:   v = Z_W'(64'sd16);
         5'd27:   v = Z_W'(64'sd8);
         5'd28:   v = Z_W'(64'sd4);
         5'd29:   v = Z_W'(64'sd2);
         default: v = '0;
      endcase
      return v;
   endfunction

   // Product of an angle and 0.1 in Q0.32, rounded half up to whole units.
   function automatic logic signed [ANG_W-1:0] scale_round(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + PROD_W'(64'sd2147483648);
      return t[63:32];
   endfunction

   function automatic logic signed [PROD_W-1:0] round_fb(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = p + PROD_W'(64'sd1 <<< (FRAC_BITS - 1));
      return t >>> FRAC_BITS;
   endfunction

   function automatic logic signed [ANG_W-1:0] sat_s32(input logic signed [PROD_W-1:0] v);
      logic signed [ANG_W-1:0] r;
      if (v > S32_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < S32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[ANG_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/three_encoder_odometry_integrator.sv
// Top level of the three-encoder odometry integrator: sequencer, state and stream ports.
// Each word is scaled by 0.1 and differenced on the shared multiplier, the turn and lateral terms
// are formed, the heading is wrapped by restoring subtraction and loaded to start the CORDIC, then
// the rotation products, pose update and output load follow. A new word is taken only when idle,
// after the last result is loaded; a result not yet taken holds the next load.
// Synchronous reset restores the default gains and clears the pose and encoder history.
`default_nettype none
module three_encoder_odometry_integrator
   import odo_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   // left_angle [31:0], right_angle [63:32], front_angle [95:64]
   input  wire  [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   // pose_x_out [31:0], pose_y_out [63:32], heading_out [82:64], zeros [87:83]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire                   csr_we,
   input  wire  [CSR_ADDR_W-1:0] csr_addr,
   input  wire  [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic signed [HEAD_W-1:0]   PI_H     = HEAD_W'(PI_QF);
   localparam logic signed [WRAP_W:0]     WRAP_OFS = (WRAP_W + 1)'(PI_QF + WRAP_BIAS);
   localparam logic [WRAP_W-1:0]          TWO_PI_W = WRAP_W'(TWO_PI_QF);
   localparam logic signed [MUL_W-1:0]    TENTH_M  = MUL_W'(TENTH_Q32);

   typedef enum logic [4:0] {
      S_IDLE,
      S_SCL_L,
      S_SCL_R,
      S_SCL_F,
      S_DIFF,
      S_TURN,
      S_TURN_CAP,
      S_LEVER,
      S_LAT,
      S_WRAP,
      S_HEAD,
      S_CSTART,
      S_CWAIT,
      S_ROT_XC,
      S_ROT_LS,
      S_ROT_FS,
      S_ROT_LC,
      S_ROT_Y,
      S_POS,
      S_OUT
   } odo_state_type;

   odo_state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0]    gain_ff;
   logic signed [ANG_W-1:0]  lever_ff;

   logic signed [ANG_W-1:0]  left_raw_ff, left_raw_in, right_raw_ff, right_raw_in;
   logic signed [ANG_W-1:0]  front_raw_ff, front_raw_in;
   logic signed [ANG_W-1:0]  l_ff, l_in, r_ff, r_in;
   logic signed [ANG_W-1:0]  prev_l_ff, prev_l_in, prev_r_ff, prev_r_in, prev_f_ff, prev_f_in;
   logic signed [ANG_W-1:0]  dl_ff, dl_in, dr_ff, dr_in, df_ff, df_in;
   logic signed [ANG_W-1:0]  fwd_ff, fwd_in, turn_ff, turn_in, lat_ff, lat_in;
   logic signed [ANG_W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [HEAD_W-1:0] head_ff, head_in;
   logic [WRAP_W-1:0]        wrap_ff, wrap_in;
   logic [WRAP_CNT_W-1:0]    wcnt_ff, wcnt_in;
   logic signed [PROD_W-1:0] part_ff, part_in, acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   logic                     cor_start, cor_done;
   logic signed [CS_W-1:0]   cor_cos, cor_sin;

   logic signed [ANG_W-1:0]  f_scaled;
   logic signed [WRAP_W:0]   wrap_sum;
   logic [WRAP_W-1:0]        wrap_div;
   logic                     req_acc;

   odo_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   odo_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (head_ff),
      .done_ff (cor_done),
      .cos_ff  (cor_cos),
      .sin_ff  (cor_sin)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      left_raw_in  = left_raw_ff;
      right_raw_in = right_raw_ff;
      front_raw_in = front_raw_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      prev_f_in    = prev_f_ff;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      df_in        = df_ff;
      fwd_in       = fwd_ff;
      turn_in      = turn_ff;
      lat_in       = lat_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      head_in      = head_ff;
      wrap_in      = wrap_ff;
      wcnt_in      = wcnt_ff;
      part_in      = part_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_a        = '0;
      mul_b        = '0;
      cor_start    = 1'b0;
      f_scaled     = -scale_round(prod);
      wrap_sum     = (WRAP_W + 1)'(head_ff) + (WRAP_W + 1)'(turn_ff) + WRAP_OFS;
      wrap_div     = TWO_PI_W << wcnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               left_raw_in  = req_tdata[31:0];
               right_raw_in = req_tdata[63:32];
               front_raw_in = req_tdata[95:64];
               state_in     = S_SCL_L;
            end
         end
         S_SCL_L: begin
            mul_a    = MUL_W'(left_raw_ff);
            mul_b    = TENTH_M;
            state_in = S_SCL_R;
         end
         S_SCL_R: begin
            mul_a    = MUL_W'(right_raw_ff);
            mul_b    = TENTH_M;
            l_in     = -scale_round(prod);
            state_in = S_SCL_F;
         end
         S_SCL_F: begin
            mul_a    = MUL_W'(front_raw_ff);
            mul_b    = TENTH_M;
            r_in     = scale_round(prod);
            state_in = S_DIFF;
         end
         S_DIFF: begin
            dl_in     = l_ff - prev_l_ff;
            dr_in     = r_ff - prev_r_ff;
            df_in     = f_scaled - prev_f_ff;
            prev_l_in = l_ff;
            prev_r_in = r_ff;
            prev_f_in = f_scaled;
            state_in  = S_TURN;
         end
         S_TURN: begin
            mul_a    = MUL_W'(dr_ff - dl_ff);
            mul_b    = MUL_W'(gain_ff);
            fwd_in   = (dl_ff + dr_ff) >>> 1;
            state_in = S_TURN_CAP;
         end
         S_TURN_CAP: begin
            turn_in  = sat_s32(-round_fb(prod));
            state_in = S_LEVER;
         end
         S_LEVER: begin
            mul_a    = MUL_W'(lever_ff);
            mul_b    = MUL_W'(turn_ff);
            wrap_in  = wrap_sum[WRAP_W-1:0];
            wcnt_in  = WRAP_CNT_W'(WRAP_TOP);
            state_in = S_LAT;
         end
         S_LAT: begin
            lat_in   = sat_s32(PROD_W'(df_ff) - round_fb(prod));
            state_in = S_WRAP;
         end
         S_WRAP: begin
            if (wrap_ff >= wrap_div) begin
               wrap_in = wrap_ff - wrap_div;
            end
            if (wcnt_ff == '0) begin
               state_in = S_HEAD;
            end else begin
               wcnt_in = wcnt_ff - 1'b1;
            end
         end
         S_HEAD: begin
            head_in  = HEAD_W'(wrap_ff) - PI_H;
            state_in = S_CSTART;
         end
         S_CSTART: begin
            cor_start = 1'b1;
            state_in  = S_CWAIT;
         end
         S_CWAIT: begin
            if (cor_done) begin
               state_in = S_ROT_XC;
            end
         end
         S_ROT_XC: begin
            mul_a    = MUL_W'(fwd_ff);
            mul_b    = MUL_W'(cor_cos);
            state_in = S_ROT_LS;
         end
         S_ROT_LS: begin
            mul_a    = MUL_W'(lat_ff);
            mul_b    = MUL_W'(cor_sin);
            part_in  = prod;
            state_in = S_ROT_FS;
         end
         S_ROT_FS: begin
            mul_a    = MUL_W'(fwd_ff);
            mul_b    = MUL_W'(cor_sin);
            acc_x_in = part_ff - prod;
            state_in = S_ROT_LC;
         end
         S_ROT_LC: begin
            mul_a    = MUL_W'(lat_ff);
            mul_b    = MUL_W'(cor_cos);
            part_in  = prod;
            state_in = S_ROT_Y;
         end
         S_ROT_Y: begin
            acc_y_in = part_ff + prod;
            state_in = S_POS;
         end
         S_POS: begin
            pos_x_in = sat_s32(PROD_W'(pos_x_ff) + round_fb(acc_x_ff));
            pos_y_in = sat_s32(PROD_W'(pos_y_ff) + round_fb(acc_y_ff));
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {(RSP_DATA_W - 2 * ANG_W - HEAD_OUT_W)'(0),
                               HEAD_OUT_W'(head_ff), pos_y_ff, pos_x_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= GAIN_RESET;
         lever_ff     <= '0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         prev_f_ff    <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         head_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         prev_f_ff    <= prev_f_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         head_ff      <= head_in;
         if (csr_we) begin
            case (odo_csr_type'(csr_addr))
               CSR_TURN_GAIN:   gain_ff  <= csr_wdata;
               CSR_FRONT_LEVER: lever_ff <= csr_wdata;
               default:         gain_ff  <= gain_ff;
            endcase
         end
      end
      left_raw_ff  <= left_raw_in;
      right_raw_ff <= right_raw_in;
      front_raw_ff <= front_raw_in;
      l_ff         <= l_in;
      r_ff         <= r_in;
      dl_ff        <= dl_in;
      dr_ff        <= dr_in;
      df_ff        <= df_in;
      fwd_ff       <= fwd_in;
      turn_ff      <= turn_in;
      lat_ff       <= lat_in;
      wrap_ff      <= wrap_in;
      wcnt_ff      <= wcnt_in;
      part_ff      <= part_in;
      acc_x_ff     <= acc_x_in;
      acc_y_ff     <= acc_y_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // An accepted word always starts the scaling sequence.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == S_SCL_L))
      else $error("accepted word did not start the sequence");

   // The stored heading never leaves the wrapped range.
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      (head_ff >= -PI_H) && (head_ff < PI_H))
      else $error("heading outside the wrapped range");

   // The CORDIC reports completion only while the sequencer waits for it.
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      cor_done |-> (state_ff == S_CWAIT))
      else $error("CORDIC finished outside its wait state");

   // A new result word appears only from the output state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result word raised outside the output state");

endmodule
`default_nettype wire

FILE: rtl/odo_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none
module odo_mul
   import odo_pkg::*;
(
   input  wire                       clock,
   input  wire  signed [MUL_W-1:0]   mul_a,
   input  wire  signed [MUL_W-1:0]   mul_b,
   output logic signed [PROD_W-1:0]  prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

FILE: rtl/odo_cordic.sv
// Iterative CORDIC giving cosine and sine of a heading, one micro-rotation per cycle.
`default_nettype none
module odo_cordic
   import odo_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire  signed [HEAD_W-1:0] angle,
   output logic                     done_ff,
   output logic signed [CS_W-1:0]   cos_ff,
   output logic signed [CS_W-1:0]   sin_ff
);

   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   localparam logic signed [Z_W-1:0]  PI_Z      = Z_W'(PI_Q30);
   localparam logic signed [Z_W-1:0]  HALF_PI_Z = Z_W'(HALF_PI_Q30);
   localparam logic signed [XY_W-1:0] K_XY      = XY_W'(CORDIC_K_Q30);
   localparam logic signed [XY_W-1:0] HALF_LSB  = XY_W'(64'sd1 <<< (CORDIC_SHIFT - 1));

   typedef enum logic [1:0] {
      C_IDLE,
      C_RUN,
      C_ROUND
   } cor_state_type;

   cor_state_type           state_ff, state_in;
   logic [STEP_W-1:0]       cnt_ff, cnt_in;
   logic signed [XY_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic                    flip_ff, flip_in;
   logic                    done_in;
   logic signed [CS_W-1:0]  cos_in, sin_in;

   logic signed [Z_W-1:0]   z_start;
   logic signed [XY_W-1:0]  x_sh, y_sh, x_rnd, y_rnd;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      flip_in  = flip_ff;
      done_in  = 1'b0;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      z_start  = Z_W'(angle) <<< CORDIC_SHIFT;
      x_sh     = x_ff >>> cnt_ff;
      y_sh     = y_ff >>> cnt_ff;
      x_rnd    = (x_ff + HALF_LSB) >>> CORDIC_SHIFT;
      y_rnd    = (y_ff + HALF_LSB) >>> CORDIC_SHIFT;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               x_in     = K_XY;
               y_in     = '0;
               cnt_in   = '0;
               state_in = C_RUN;
               if (z_start > HALF_PI_Z) begin
                  z_in    = z_start - PI_Z;
                  flip_in = 1'b1;
               end else if (z_start < -HALF_PI_Z) begin
                  z_in    = z_start + PI_Z;
                  flip_in = 1'b1;
               end else begin
                  z_in    = z_start;
                  flip_in = 1'b0;
               end
            end
         end
         C_RUN: begin
            if (!z_ff[Z_W-1]) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - atan_q30(5'(cnt_ff));
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + atan_q30(5'(cnt_ff));
            end
            if (cnt_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = C_ROUND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         C_ROUND: begin
            cos_in   = flip_ff ? -CS_W'(x_rnd) : CS_W'(x_rnd);
            sin_in   = flip_ff ? -CS_W'(y_rnd) : CS_W'(y_rnd);
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the three-encoder odometry integrator: directed table, then random.
`default_nettype none
module tb
   import odo_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     Q_FRAC          = 16;
   localparam int     ROT_SHIFT       = 30 - Q_FRAC;
   localparam int     ROT_STEPS       = 16;
   localparam longint TENTH           = 64'sd429496730;
   localparam longint PI_Q            = 64'sd3373259426;
   localparam longint HALF_PI         = PI_Q / 2;
   localparam longint PI_FIX          = (PI_Q + (64'sd1 <<< (29 - Q_FRAC))) >>> ROT_SHIFT;
   localparam longint TWO_PI_FIX      = 2 * PI_FIX;
   localparam longint GAIN_K          = 64'sd652032875;
   localparam longint ATAN_Z [ROT_STEPS] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851, 8388437,
      4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768
   };
   localparam int     WORDS_PER_PHASE = 150;
   localparam int     PHASES          = 7;
   localparam int     DRAIN_CYCLES    = 64;
   localparam int     CYCLE_LIMIT     = 600000;
   localparam int     REPORT_MAX      = 10;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [18:0] h;
   } pose_type;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      odo_csr_type  addr;
      logic [31:0]  wdata;
      logic [31:0]  l;
      logic [31:0]  r;
      logic [31:0]  f;
      bit           known;
      pose_type     pose;
   } row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   longint prev_l = 0, prev_r = 0, prev_f = 0;
   longint pos_x = 0, pos_y = 0, head = 0;
   longint gain = 327680, lever = 0;

   pose_type poses_due[$];
   int    words_sent = 0;
   int    poses_checked = 0;
   int    mismatches = 0;
   int    settings_written = 0;
   int    cycle_count = 0;
   bit    req_steady = 1'b0;
   bit    rsp_steady = 1'b0;

   three_encoder_odometry_integrator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint tenth(input logic [31:0] a);
      return round_shift(longint'($signed(a)) * TENTH, 32);
   endfunction

   function automatic void cos_sin(input longint h, output longint c, output longint s);
      longint z, x, y, nx;
      bit     flip;
      z = h * (64'sd1 <<< ROT_SHIFT);
      x = GAIN_K;
      y = 0;
      flip = 1'b0;
      if (z > HALF_PI) begin
         z = z - PI_Q;
         flip = 1'b1;
      end else if (z < -HALF_PI) begin
         z = z + PI_Q;
         flip = 1'b1;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - ATAN_Z[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + ATAN_Z[i];
         end
         x = nx;
      end
      x = round_shift(x, ROT_SHIFT);
      y = round_shift(y, ROT_SHIFT);
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic pose_type advance_pose(input logic [31:0] la, ra, fa);
      longint   l, r, f, dl, dr, df, fwd, turn, lat, h, c, s;
      pose_type p;
      l = -tenth(la);
      r = tenth(ra);
      f = -tenth(fa);
      dl = l - prev_l;
      dr = r - prev_r;
      df = f - prev_f;
      prev_l = l;
      prev_r = r;
      prev_f = f;
      fwd = (dl + dr) >>> 1;
      turn = clamp32(-round_shift((dr - dl) * gain, Q_FRAC));
      lat = clamp32(df - round_shift(lever * turn, Q_FRAC));
      h = (head + turn + PI_FIX) % TWO_PI_FIX;
      if (h < 0) h = h + TWO_PI_FIX;
      head = h - PI_FIX;
      cos_sin(head, c, s);
      pos_x = clamp32(pos_x + round_shift(fwd * c - lat * s, Q_FRAC));
      pos_y = clamp32(pos_y + round_shift(fwd * s + lat * c, Q_FRAC));
      p.x = pos_x[31:0];
      p.y = pos_y[31:0];
      p.h = head[18:0];
      return p;
   endfunction

   function automatic int draw_idle(inout bit steady);
      if ($urandom_range(0, 39) == 0) steady = !steady;
      return steady ? 0 : int'($urandom_range(0, 12));
   endfunction

   function automatic logic [31:0] nudge(input logic [31:0] a);
      int unsigned k;
      k = $urandom_range(4, 22);
      return a + 32'($signed($urandom) >>> (31 - k));
   endfunction

   function automatic logic [31:0] pick_edge();
      case ($urandom_range(0, 4))
         0:       return 32'h7fffffff;
         1:       return 32'h80000000;
         2:       return 32'hffffffff;
         3:       return 32'h00000001;
         default: return 32'h00000000;
      endcase
   endfunction

   function automatic row_type word_row(input logic [31:0] la, ra, fa, input bit known = 1'b0,
                                        input pose_type typed = '0);
      row_type w;
      w.kind = ROW_WORD;
      w.addr = CSR_TURN_GAIN;
      w.wdata = '0;
      w.l = la;
      w.r = ra;
      w.f = fa;
      w.known = known;
      w.pose = typed;
      return w;
   endfunction

   function automatic row_type csr_row(input odo_csr_type idx, input logic [31:0] v);
      row_type w;
      w = word_row('0, '0, '0);
      w.kind = ROW_CSR;
      w.addr = idx;
      w.wdata = v;
      return w;
   endfunction

   task automatic flag_error(input string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("ERROR at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_pose(input pose_type got);
      pose_type want;
      if (poses_due.size() == 0) begin
         flag_error($sformatf("pose word with none expected: x=%h y=%h heading=%h",
                              got.x, got.y, got.h));
      end else begin
         want = poses_due.pop_front();
         poses_checked++;
         if (got.x !== want.x)
            flag_error($sformatf("pose_x expected %h, got %h", want.x, got.x));
         if (got.y !== want.y)
            flag_error($sformatf("pose_y expected %h, got %h", want.y, got.y));
         if (got.h !== want.h)
            flag_error($sformatf("heading expected %h, got %h", want.h, got.h));
      end
   endtask

   task automatic send_word(input logic [31:0] la, ra, fa, input bit known = 1'b0,
                            input pose_type typed = '0);
      int       gap;
      pose_type p;
      gap = draw_idle(req_steady);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {fa, ra, la};
      req_tvalid = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_tready);
      p = advance_pose(la, ra, fa);
      poses_due.push_back(known ? typed : p);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(input odo_csr_type idx, input logic [31:0] v);
      req_tvalid = 1'b0;
      while (poses_due.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_TURN_GAIN:   gain = longint'({32'b0, v});
         CSR_FRONT_LEVER: lever = longint'($signed(v));
         default:         ;
      endcase
      settings_written++;
   endtask

   initial begin
      pose_type got;
      int       stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = draw_idle(rsp_steady);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do begin
            @(posedge clock);
         end while (!rsp_tvalid);
         got.x = rsp_tdata[31:0];
         got.y = rsp_tdata[63:32];
         got.h = rsp_tdata[82:64];
         check_pose(got);
         @(negedge clock);
      end
   end

   initial begin
      row_type     plan[$];
      logic [31:0] cur_l, cur_r, cur_f;
      logic [31:0] new_gain, new_lever;
      int unsigned pick;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = CSR_TURN_GAIN;
      csr_wdata = '0;

      // Zero input straight after reset leaves the pose and heading at zero.
      plan.push_back(word_row(32'h0, 32'h0, 32'h0, 1'b1, '0));
      plan.push_back(word_row(32'h0, 32'h0, 32'h0, 1'b1, '0));
      plan.push_back(word_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
      plan.push_back(word_row(32'h80000000, 32'h80000000, 32'h80000000));
      plan.push_back(word_row(32'h7fffffff, 32'h80000000, 32'h00000000));
      plan.push_back(word_row(32'h80000000, 32'h7fffffff, 32'h7fffffff));
      plan.push_back(csr_row(CSR_TURN_GAIN, 32'hffffffff));
      plan.push_back(word_row(32'h7fffffff, 32'h80000000, 32'h80000000));
      plan.push_back(word_row(32'h80000000, 32'h7fffffff, 32'h7fffffff));
      plan.push_back(csr_row(CSR_FRONT_LEVER, 32'h7fffffff));
      plan.push_back(word_row(32'h40000000, 32'hc0000000, 32'h00000000));
      plan.push_back(word_row(32'h00001000, 32'h00002000, 32'hffffff00));
      plan.push_back(csr_row(CSR_FRONT_LEVER, 32'h80000000));
      plan.push_back(word_row(32'hc0000000, 32'h40000000, 32'h7fffffff));
      plan.push_back(csr_row(CSR_TURN_GAIN, 32'h00000000));
      plan.push_back(word_row(32'h7fffffff, 32'h80000000, 32'h7fffffff));
      plan.push_back(word_row(32'h80000000, 32'h7fffffff, 32'h80000000));
      plan.push_back(csr_row(CSR_TURN_GAIN, 32'h00000001));
      plan.push_back(word_row(32'h00000001, 32'hffffffff, 32'h00000001));
      plan.push_back(word_row(32'h00000005, 32'h00000005, 32'h00000005));
      plan.push_back(csr_row(CSR_TURN_GAIN, 32'd327680));
      plan.push_back(csr_row(CSR_FRONT_LEVER, 32'h00000000));
      plan.push_back(word_row(32'h00032000, 32'h00064000, 32'h00010000));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            write_csr(plan[i].addr, plan[i].wdata);
         end else begin
            send_word(plan[i].l, plan[i].r, plan[i].f, plan[i].known, plan[i].pose);
         end
      end

      cur_l = 32'h00032000;
      cur_r = 32'h00064000;
      cur_f = 32'h00010000;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               new_gain = 32'd327680;
               new_lever = 32'h00000000;
            end
            1: begin
               new_gain = 32'hffffffff;
               new_lever = 32'h7fffffff;
            end
            2: begin
               new_gain = 32'h00000001;
               new_lever = 32'h80000000;
            end
            3: begin
               new_gain = $urandom_range(32'h4000, 32'h100000);
               new_lever = 32'($signed($urandom) >>> 13);
            end
            4: begin
               new_gain = $urandom;
               new_lever = $urandom;
            end
            5: begin
               new_gain = 32'h00010000;
               new_lever = 32'($signed($urandom) >>> 15);
            end
            default: begin
               new_gain = $urandom_range(32'h4000, 32'h100000);
               new_lever = 32'($signed($urandom) >>> 14);
            end
         endcase
         write_csr(CSR_TURN_GAIN, new_gain);
         write_csr(CSR_FRONT_LEVER, new_lever);
         repeat (WORDS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               cur_l = nudge(cur_l);
               cur_r = nudge(cur_r);
               cur_f = nudge(cur_f);
            end else if (pick < 92) begin
               cur_l = $urandom;
               cur_r = $urandom;
               cur_f = $urandom;
            end else begin
               cur_l = pick_edge();
               cur_r = pick_edge();
               cur_f = pick_edge();
            end
            send_word(cur_l, cur_r, cur_f);
         end
      end
      req_tvalid = 1'b0;

      while (poses_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d encoder words under %0d register writes (gain and lever extremes).",
               words_sent, settings_written);
      $display("Checked %0d pose words, %0d mismatches.", poses_checked, mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: three_encoder_odometry_integrator.f
rtl/odo_pkg.sv
rtl/odo_mul.sv
rtl/odo_cordic.sv
rtl/three_encoder_odometry_integrator.sv
verif/tb.sv
